/* rtl/core/prq_pkg.sv */
package prq_pkg;

    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int QUANTUM_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [KIND_W-1:0] KIND_ENQ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STEAL = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT = 2'd1;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd3;

    // per-cycle command broadcast along the cell row
    typedef struct packed {
        logic enq;
        logic pick;
        logic front;
    } cell_ctrl_t;

endpackage

/* rtl/core/prq_cell.sv */
module prq_cell #(
    parameter int ID_BITS   = 8,
    parameter int PRIO_BITS = 6
) (
    input  logic                  clk,
    input  prq_pkg::cell_ctrl_t   ctrl,
    input  logic                  occ,
    input  logic [ID_BITS-1:0]    new_id,
    input  logic [PRIO_BITS-1:0]  new_prio,
    input  logic                  left_after,
    input  logic [ID_BITS-1:0]    left_id,
    input  logic [PRIO_BITS-1:0]  left_prio,
    input  logic [ID_BITS-1:0]    right_id,
    input  logic [PRIO_BITS-1:0]  right_prio,
    output logic [ID_BITS-1:0]    id,
    output logic [PRIO_BITS-1:0]  prio,
    output logic                  after,
    output logic                  match
);

    logic [ID_BITS-1:0]   id_reg;
    logic [ID_BITS-1:0]   id_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;

    // entry stays ahead of the new word
    assign after = occ && (ctrl.front ? (prio_reg < new_prio) : (prio_reg <= new_prio));
    assign match = occ && (id_reg == new_id);
    assign id    = id_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        id_next   = id_reg;
        prio_next = prio_reg;
        if (ctrl.enq && !after)
        begin
            if (left_after)
            begin
                id_next   = new_id;
                prio_next = new_prio;
            end
            else
            begin
                id_next   = left_id;
                prio_next = left_prio;
            end
        end
        else if (ctrl.pick)
        begin
            id_next   = right_id;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

endmodule

/* rtl/core/prq_chain.sv */
module prq_chain #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PRIO_BITS   = 6,
    parameter int ID_BITS     = 8,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  clk,
    input  prq_pkg::cell_ctrl_t   ctrl,
    input  logic [CNT_W-1:0]      count,
    input  logic [ID_BITS-1:0]    new_id,
    input  logic [PRIO_BITS-1:0]  new_prio,
    output logic                  dup,
    output logic [ID_BITS-1:0]    head_id,
    output logic [PRIO_BITS-1:0]  head_prio,
    output logic [ID_BITS-1:0]    tail_id,
    output logic [PRIO_BITS-1:0]  tail_prio
);

    logic [ID_BITS-1:0]   cell_id   [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0] cell_prio [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_after;
    logic [QUEUE_DEPTH-1:0] cell_match;
    logic [QUEUE_DEPTH-1:0] cell_occ;
    logic [QUEUE_DEPTH-1:0] cell_tail;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                 l_after;
        logic [ID_BITS-1:0]   l_id;
        logic [PRIO_BITS-1:0] l_prio;
        logic [ID_BITS-1:0]   r_id;
        logic [PRIO_BITS-1:0] r_prio;

        assign cell_occ[i]  = CNT_W'(i) < count;
        assign cell_tail[i] = CNT_W'(i + 1) == count;

        if (i == 0)
        begin : g_first
            assign l_after = 1'b1;
            assign l_id    = new_id;
            assign l_prio  = new_prio;
        end
        else
        begin : g_mid
            assign l_after = cell_after[i-1];
            assign l_id    = cell_id[i-1];
            assign l_prio  = cell_prio[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign r_id   = cell_id[i];
            assign r_prio = cell_prio[i];
        end
        else
        begin : g_inner
            assign r_id   = cell_id[i+1];
            assign r_prio = cell_prio[i+1];
        end

        prq_cell #(
            .ID_BITS   (ID_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occ        (cell_occ[i]),
            .new_id     (new_id),
            .new_prio   (new_prio),
            .left_after (l_after),
            .left_id    (l_id),
            .left_prio  (l_prio),
            .right_id   (r_id),
            .right_prio (r_prio),
            .id         (cell_id[i]),
            .prio       (cell_prio[i]),
            .after      (cell_after[i]),
            .match      (cell_match[i])
        );
    end

    assign dup       = |cell_match;
    assign head_id   = cell_id[0];
    assign head_prio = cell_prio[0];

    always_comb
    begin
        tail_id   = '0;
        tail_prio = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            tail_id   = tail_id   | (cell_id[k]   & {ID_BITS{cell_tail[k]}});
            tail_prio = tail_prio | (cell_prio[k] & {PRIO_BITS{cell_tail[k]}});
        end
    end

endmodule

/* rtl/core/priority_ready_queue_scheduler_top.sv */
// Priority ready queue scheduler. Tasks wait in a row of shift cells kept
// sorted by priority (lower value first); enqueue, pick, tick and steal are
// issued with start while busy is low. The command is registered on the
// accept edge and executed on the next one, and a new command is only
// taken once busy is low again; done pulses for one cycle after the
// execute edge with the result word. The receiver cannot stall: the result
// must be captured while done is high. Duplicate detection and the tail
// select are a compare across all cells in the execute cycle, which sets
// the clock. Configuration writes are always taken (cfg_ready stays high)
// and should only be made while busy is low.
module priority_ready_queue_scheduler_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PRIO_BITS   = 6,
    parameter int ID_BITS     = 8,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [prq_pkg::KIND_W-1:0]      kind,
    input  logic [ID_BITS-1:0]              task_id,
    input  logic [PRIO_BITS-1:0]            task_prio,
    input  logic                            was_runnable,
    input  logic                            insert_front,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [prq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prq_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            done,
    output logic [prq_pkg::STATUS_W-1:0]    status,
    output logic [ID_BITS-1:0]              out_id,
    output logic [PRIO_BITS-1:0]            out_prio,
    output logic                            out_valid,
    output logic                            resched,
    output logic                            requeue_front,
    output logic [CNT_W-1:0]                queued
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [prq_pkg::KIND_W-1:0]       kind_reg;
    logic [ID_BITS-1:0]               id_reg;
    logic [PRIO_BITS-1:0]             prio_reg;
    logic                             runnable_reg;
    logic                             front_reg;

    logic [CNT_W-1:0]                 count_reg;
    logic [CNT_W-1:0]                 count_next;
    logic [ID_BITS-1:0]               cur_id_reg;
    logic [ID_BITS-1:0]               cur_id_next;
    logic [PRIO_BITS-1:0]             cur_prio_reg;
    logic [PRIO_BITS-1:0]             cur_prio_next;
    logic                             cur_busy_reg;
    logic                             cur_busy_next;
    logic [prq_pkg::QUANTUM_W-1:0]    slice_reg;
    logic [prq_pkg::QUANTUM_W-1:0]    slice_next;
    logic                             resched_reg;
    logic                             resched_next;
    logic [prq_pkg::QUANTUM_W-1:0]    quantum_reg;
    logic                             preempt_reg;

    logic [prq_pkg::STATUS_W-1:0]     status_reg;
    logic [prq_pkg::STATUS_W-1:0]     status_next;
    logic [ID_BITS-1:0]               oid_reg;
    logic [ID_BITS-1:0]               oid_next;
    logic [PRIO_BITS-1:0]             oprio_reg;
    logic [PRIO_BITS-1:0]             oprio_next;
    logic                             ovalid_reg;
    logic                             ovalid_next;
    logic                             rqf_reg;
    logic                             rqf_next;

    prq_pkg::cell_ctrl_t              ctrl;
    logic                             dup;
    logic                             full;
    logic                             empty;
    logic                             accept;
    logic [ID_BITS-1:0]               head_id;
    logic [PRIO_BITS-1:0]             head_prio;
    logic [ID_BITS-1:0]               tail_id;
    logic [PRIO_BITS-1:0]             tail_prio;

    assign accept    = start && !busy_reg;
    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign cfg_ready = 1'b1;

    prq_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PRIO_BITS   (PRIO_BITS),
        .ID_BITS     (ID_BITS),
        .CNT_W       (CNT_W)
    ) u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .count     (count_reg),
        .new_id    (id_reg),
        .new_prio  (prio_reg),
        .dup       (dup),
        .head_id   (head_id),
        .head_prio (head_prio),
        .tail_id   (tail_id),
        .tail_prio (tail_prio)
    );

    always_comb
    begin
        ctrl.enq   = busy_reg && (kind_reg == prq_pkg::KIND_ENQ) && !dup && !full;
        ctrl.pick  = busy_reg && (kind_reg == prq_pkg::KIND_PICK) && !empty;
        ctrl.front = front_reg;

        count_next    = count_reg;
        cur_id_next   = cur_id_reg;
        cur_prio_next = cur_prio_reg;
        cur_busy_next = cur_busy_reg;
        slice_next    = slice_reg;
        resched_next  = resched_reg;
        status_next   = prq_pkg::ST_OK;
        oid_next      = '0;
        oprio_next    = '0;
        ovalid_next   = 1'b0;
        rqf_next      = 1'b0;

        case (kind_reg)
            prq_pkg::KIND_ENQ:
            begin
                if (dup)
                begin
                    status_next = prq_pkg::ST_DUP;
                end
                else if (full)
                begin
                    status_next = prq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (!runnable_reg && preempt_reg && cur_busy_reg &&
                        (prio_reg < cur_prio_reg))
                    begin
                        resched_next = 1'b1;
                        rqf_next     = 1'b1;
                    end
                end
            end
            prq_pkg::KIND_PICK:
            begin
                resched_next = 1'b0;
                if (empty)
                begin
                    status_next   = prq_pkg::ST_EMPTY;
                    cur_busy_next = 1'b0;
                    slice_next    = '0;
                end
                else
                begin
                    cur_id_next   = head_id;
                    cur_prio_next = head_prio;
                    cur_busy_next = 1'b1;
                    slice_next    = quantum_reg;
                    count_next    = count_reg - CNT_W'(1);
                    oid_next      = head_id;
                    oprio_next    = head_prio;
                    ovalid_next   = 1'b1;
                end
            end
            prq_pkg::KIND_TICK:
            begin
                if (cur_busy_reg)
                begin
                    if (slice_reg != '0)
                    begin
                        slice_next = slice_reg - (prq_pkg::QUANTUM_W)'(1);
                    end
                    if (slice_next == '0)
                    begin
                        resched_next = 1'b1;
                    end
                end
            end
            prq_pkg::KIND_STEAL:
            begin
                if (empty)
                begin
                    status_next = prq_pkg::ST_EMPTY;
                end
                else
                begin
                    oid_next    = tail_id;
                    oprio_next  = tail_prio;
                    ovalid_next = 1'b1;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = prq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            count_reg    <= '0;
            cur_id_reg   <= '0;
            cur_prio_reg <= '0;
            cur_busy_reg <= 1'b0;
            slice_reg    <= '0;
            resched_reg  <= 1'b0;
            quantum_reg  <= prq_pkg::QUANTUM_RESET;
            preempt_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                busy_reg     <= 1'b0;
                count_reg    <= count_next;
                cur_id_reg   <= cur_id_next;
                cur_prio_reg <= cur_prio_next;
                cur_busy_reg <= cur_busy_next;
                slice_reg    <= slice_next;
                resched_reg  <= resched_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == prq_pkg::CFG_QUANTUM)
                begin
                    quantum_reg <= cfg_data[prq_pkg::QUANTUM_W-1:0];
                end
                else if (cfg_index == prq_pkg::CFG_PREEMPT)
                begin
                    preempt_reg <= cfg_data[0];
                end
            end
        end
    end

    // command and result words
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= kind;
            id_reg       <= task_id;
            prio_reg     <= task_prio;
            runnable_reg <= was_runnable;
            front_reg    <= insert_front;
        end
        if (busy_reg)
        begin
            status_reg <= status_next;
            oid_reg    <= oid_next;
            oprio_reg  <= oprio_next;
            ovalid_reg <= ovalid_next;
            rqf_reg    <= rqf_next;
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign out_id        = oid_reg;
    assign out_prio      = oprio_reg;
    assign out_valid     = ovalid_reg;
    assign resched       = resched_reg;
    assign requeue_front = rqf_reg;
    assign queued        = count_reg;

endmodule

/* rtl/core/prq_checker.sv */
module prq_checker #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PRIO_BITS   = 6,
    parameter int ID_BITS     = 8,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            done,
    input  logic [prq_pkg::STATUS_W-1:0]    status,
    input  logic [ID_BITS-1:0]              out_id,
    input  logic [PRIO_BITS-1:0]            out_prio,
    input  logic                            out_valid,
    input  logic                            resched,
    input  logic                            requeue_front,
    input  logic [CNT_W-1:0]                queued
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("word in flight produced no result");

    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_valid |-> status == prq_pkg::ST_OK)
        else $error("task returned with a failure status");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == prq_pkg::ST_EMPTY |-> queued == '0 && !out_valid)
        else $error("empty status with tasks queued");

    a_requeue_resched: assert property (@(posedge clk) disable iff (!rst_n)
        done && requeue_front |-> resched && status == prq_pkg::ST_OK)
        else $error("requeue without reschedule request");

endmodule

bind priority_ready_queue_scheduler_top prq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PRIO_BITS   (PRIO_BITS),
    .ID_BITS     (ID_BITS),
    .CNT_W       (CNT_W)
) u_prq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .out_id        (out_id),
    .out_prio      (out_prio),
    .out_valid     (out_valid),
    .resched       (resched),
    .requeue_front (requeue_front),
    .queued        (queued)
);

/* sim/priority_ready_queue_scheduler_top_tb.sv */
module priority_ready_queue_scheduler_top_tb;

    localparam int QDEPTH       = 16;
    localparam int ID_W         = 8;
    localparam int PRIO_W       = 6;
    localparam int CNT_W        = 5;
    localparam int CLK_PERIOD   = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [prq_pkg::STATUS_W-1:0] status;
        logic [ID_W-1:0]              id;
        logic [PRIO_W-1:0]            prio;
        logic                         valid;
        logic                         resched;
        logic                         requeue;
        logic [CNT_W-1:0]             queued;
    } sched_word_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [prq_pkg::KIND_W-1:0]     kind;
    logic [ID_W-1:0]                task_id;
    logic [PRIO_W-1:0]              task_prio;
    logic                           was_runnable;
    logic                           insert_front;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [prq_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [prq_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           done;
    logic [prq_pkg::STATUS_W-1:0]   status;
    logic [ID_W-1:0]                out_id;
    logic [PRIO_W-1:0]              out_prio;
    logic                           out_valid;
    logic                           resched;
    logic                           requeue_front;
    logic [CNT_W-1:0]               queued;

    // scheduler shadow state
    logic [ID_W-1:0]               rq_ids [QDEPTH];
    logic [PRIO_W-1:0]             rq_prios [QDEPTH];
    int                            rq_count;
    logic [ID_W-1:0]               cur_id;
    logic [PRIO_W-1:0]             cur_prio;
    bit                            cur_running;
    int                            slice_left;
    bit                            resched_req;
    logic [prq_pkg::QUANTUM_W-1:0] quantum_reg;
    bit                            preempt_reg;

    sched_word_t pending_words [$];
    sched_word_t got_word;
    sched_word_t want_word;

    int  n_sent;
    int  n_checked;
    int  n_errors;
    int  n_full;
    int  n_dup;
    int  n_empty;
    int  n_preempt;
    bit  gaps_on;

    priority_ready_queue_scheduler_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .task_id       (task_id),
        .task_prio     (task_prio),
        .was_runnable  (was_runnable),
        .insert_front  (insert_front),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .out_id        (out_id),
        .out_prio      (out_prio),
        .out_valid     (out_valid),
        .resched       (resched),
        .requeue_front (requeue_front),
        .queued        (queued)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("simulation failed");
        $finish;
    end

    function automatic sched_word_t schedule_step(logic [prq_pkg::KIND_W-1:0] k,
                                                  logic [ID_W-1:0] id,
                                                  logic [PRIO_W-1:0] prio, logic runnable,
                                                  logic front);
        sched_word_t w;
        int          pos;
        bit          dup;
        w   = '0;
        dup = 1'b0;
        if (k == prq_pkg::KIND_ENQ)
        begin
            for (int i = 0; i < rq_count; i++)
            begin
                if (rq_ids[i] == id)
                    dup = 1'b1;
            end
            if (dup)
            begin
                w.status = prq_pkg::ST_DUP;
                n_dup++;
            end
            else if (rq_count >= QDEPTH)
            begin
                w.status = prq_pkg::ST_FULL;
                n_full++;
            end
            else
            begin
                pos = 0;
                while (pos < rq_count &&
                       (front ? rq_prios[pos] < prio : rq_prios[pos] <= prio))
                    pos++;
                for (int i = rq_count; i > pos; i--)
                begin
                    rq_ids[i]   = rq_ids[i-1];
                    rq_prios[i] = rq_prios[i-1];
                end
                rq_ids[pos]   = id;
                rq_prios[pos] = prio;
                rq_count++;
                if (!runnable && preempt_reg && cur_running && prio < cur_prio)
                begin
                    resched_req = 1'b1;
                    w.requeue   = 1'b1;
                    n_preempt++;
                end
            end
        end
        else if (k == prq_pkg::KIND_PICK)
        begin
            resched_req = 1'b0;
            if (rq_count == 0)
            begin
                w.status    = prq_pkg::ST_EMPTY;
                cur_running = 1'b0;
                slice_left  = 0;
                n_empty++;
            end
            else
            begin
                cur_id      = rq_ids[0];
                cur_prio    = rq_prios[0];
                cur_running = 1'b1;
                slice_left  = int'(quantum_reg);
                for (int i = 0; i + 1 < rq_count; i++)
                begin
                    rq_ids[i]   = rq_ids[i+1];
                    rq_prios[i] = rq_prios[i+1];
                end
                rq_count--;
                w.id    = cur_id;
                w.prio  = cur_prio;
                w.valid = 1'b1;
            end
        end
        else if (k == prq_pkg::KIND_TICK)
        begin
            if (cur_running)
            begin
                if (slice_left > 0)
                    slice_left--;
                if (slice_left == 0)
                    resched_req = 1'b1;
            end
        end
        else
        begin
            if (rq_count == 0)
            begin
                w.status = prq_pkg::ST_EMPTY;
                n_empty++;
            end
            else
            begin
                w.id    = rq_ids[rq_count-1];
                w.prio  = rq_prios[rq_count-1];
                w.valid = 1'b1;
                rq_count--;
            end
        end
        w.resched = resched_req;
        w.queued  = CNT_W'(rq_count);
        return w;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            got_word = {status, out_id, out_prio, out_valid, resched, requeue_front, queued};
            if (pending_words.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("result word with nothing outstanding: %p", got_word);
            end
            else
            begin
                want_word = pending_words.pop_front();
                n_checked++;
                if (got_word !== want_word)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("mismatch at word %0d (exp/got): status %0d/%0d id %0d/%0d",
                                 n_checked, want_word.status, got_word.status,
                                 want_word.id, got_word.id,
                                 " prio %0d/%0d valid %0b/%0b resched %0b/%0b",
                                 want_word.prio, got_word.prio,
                                 want_word.valid, got_word.valid,
                                 want_word.resched, got_word.resched,
                                 " requeue %0b/%0b queued %0d/%0d",
                                 want_word.requeue, got_word.requeue,
                                 want_word.queued, got_word.queued);
                end
            end
        end
    end

    task automatic go_idle(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // start is left high on return; the next call or go_idle settles it
    task automatic send_item(logic [prq_pkg::KIND_W-1:0] k, logic [ID_W-1:0] id,
                             logic [PRIO_W-1:0] prio, logic runnable, logic front);
        @(negedge clk);
        start        <= 1'b1;
        kind         <= k;
        task_id      <= id;
        task_prio    <= prio;
        was_runnable <= runnable;
        insert_front <= front;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_words.push_back(schedule_step(k, id, prio, runnable, front));
        n_sent++;
    endtask

    task automatic wait_drain();
        go_idle(1);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [prq_pkg::CFG_IDX_W-1:0] idx,
                             logic [prq_pkg::CFG_DATA_W-1:0] data);
        wait_drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == prq_pkg::CFG_QUANTUM)
            quantum_reg = data;
        else if (idx == prq_pkg::CFG_PREEMPT)
            preempt_reg = data[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_item(int enq_pct);
        logic [prq_pkg::KIND_W-1:0] k;
        logic [ID_W-1:0]            id;
        logic [PRIO_W-1:0]          prio;
        int                         r;
        r = $urandom_range(0, 99);
        if (r < enq_pct)
            k = prq_pkg::KIND_ENQ;
        else
        begin
            r = $urandom_range(0, 9);
            k = (r < 5) ? prq_pkg::KIND_TICK : (r < 8) ? prq_pkg::KIND_PICK
                                                       : prq_pkg::KIND_STEAL;
        end
        id   = ($urandom_range(0, 3) != 0) ? ID_W'($urandom_range(0, 23))
                                           : ID_W'($urandom_range(0, 255));
        prio = ($urandom_range(0, 3) != 0) ? PRIO_W'($urandom_range(0, 7))
                                           : PRIO_W'($urandom_range(0, 63));
        send_item(k, id, prio, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (gaps_on && $urandom_range(0, 3) == 0)
            go_idle($urandom_range(1, 4));
    endtask

    task automatic test_idle_commands();
        send_item(prq_pkg::KIND_PICK, '0, '0, 1'b0, 1'b0);
        send_item(prq_pkg::KIND_STEAL, '0, '0, 1'b0, 1'b0);
        send_item(prq_pkg::KIND_TICK, '0, '0, 1'b0, 1'b0);
    endtask

    task automatic test_register_writes();
        write_reg((prq_pkg::CFG_IDX_W)'(2), (prq_pkg::CFG_DATA_W)'($urandom_range(0, 255)));
        write_reg((prq_pkg::CFG_IDX_W)'(3), (prq_pkg::CFG_DATA_W)'($urandom_range(0, 255)));
    endtask

    task automatic test_ordering();
        send_item(prq_pkg::KIND_ENQ, 8'd255, 6'd0, 1'b0, 1'b0);
        send_item(prq_pkg::KIND_ENQ, 8'd0, 6'd63, 1'b0, 1'b0);
        send_item(prq_pkg::KIND_ENQ, 8'd255, 6'd5, 1'b0, 1'b0);
        send_item(prq_pkg::KIND_ENQ, 8'd7, 6'd0, 1'b0, 1'b1);
        send_item(prq_pkg::KIND_ENQ, 8'd9, 6'd0, 1'b1, 1'b0);
        send_item(prq_pkg::KIND_PICK, '0, '0, 1'b0, 1'b0);
        repeat (4) send_item(prq_pkg::KIND_TICK, '0, '0, 1'b0, 1'b0);
        send_item(prq_pkg::KIND_STEAL, '0, '0, 1'b0, 1'b0);
        // the running task is not queued, so it may come back
        send_item(prq_pkg::KIND_ENQ, 8'd7, 6'd10, 1'b0, 1'b0);
    endtask

    task automatic test_preemption();
        write_reg(prq_pkg::CFG_PREEMPT, 8'h01);
        while (rq_count > 1)
            send_item(prq_pkg::KIND_PICK, '0, '0, 1'b0, 1'b0);
        send_item(prq_pkg::KIND_PICK, '0, '0, 1'b0, 1'b0);
        send_item(prq_pkg::KIND_ENQ, 8'd41, cur_prio - 6'd1, 1'b1, 1'b0);
        send_item(prq_pkg::KIND_ENQ, 8'd42, cur_prio + 6'd5, 1'b0, 1'b0);
        send_item(prq_pkg::KIND_ENQ, 8'd43, cur_prio, 1'b0, 1'b1);
        send_item(prq_pkg::KIND_ENQ, 8'd44, cur_prio - 6'd2, 1'b0, 1'b0);
        send_item(prq_pkg::KIND_PICK, '0, '0, 1'b0, 1'b0);
    endtask

    task automatic test_full_queue();
        int i;
        i = 0;
        while (rq_count < QDEPTH)
        begin
            send_item(prq_pkg::KIND_ENQ, ID_W'(100 + i), PRIO_W'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            i++;
        end
        send_item(prq_pkg::KIND_ENQ, 8'd200, 6'd1, 1'b0, 1'b0);
        // duplicate takes precedence over full
        send_item(prq_pkg::KIND_ENQ, 8'd100, 6'd1, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic(int n, logic [prq_pkg::QUANTUM_W-1:0] q, logic pre,
                                       bit gaps, bit pause_mid);
        write_reg(prq_pkg::CFG_QUANTUM, q);
        write_reg(prq_pkg::CFG_PREEMPT, {7'($urandom_range(0, 127)), pre});
        gaps_on = gaps;
        for (int i = 0; i < n; i++)
        begin
            if (pause_mid && i == n / 2)
                wait_drain();
            // alternate filling and draining stretches to reach full and empty
            send_random_item(((i / 25) % 2) ? 75 : 30);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = prq_pkg::KIND_ENQ;
        task_id      = '0;
        task_prio    = '0;
        was_runnable = 1'b0;
        insert_front = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rq_count     = 0;
        cur_id       = '0;
        cur_prio     = '0;
        cur_running  = 1'b0;
        slice_left   = 0;
        resched_req  = 1'b0;
        quantum_reg  = prq_pkg::QUANTUM_RESET;
        preempt_reg  = 1'b0;
        gaps_on      = 1'b0;
        n_sent       = 0;
        n_checked    = 0;
        n_errors     = 0;
        n_full       = 0;
        n_dup        = 0;
        n_empty      = 0;
        n_preempt    = 0;
        for (int i = 0; i < QDEPTH; i++)
        begin
            rq_ids[i]   = '0;
            rq_prios[i] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_commands();
        test_register_writes();
        test_ordering();
        test_preemption();
        test_full_queue();
        test_random_traffic(120, 8'd1, 1'b1, 1'b1, 1'b0);
        test_random_traffic(120, 8'd255, 1'b0, 1'b1, 1'b1);
        test_random_traffic(120, (prq_pkg::QUANTUM_W)'($urandom_range(1, 255)), 1'b1,
                            1'b1, 1'b0);
        test_random_traffic(120, 8'd2, 1'($urandom_range(0, 1)), 1'b1, 1'b0);
        test_random_traffic(120, prq_pkg::QUANTUM_RESET, 1'b1, 1'b0, 1'b0);
        wait_drain();
        repeat (4) @(posedge clk);

        $display("%0d commands sent, %0d result words checked, %0d mismatches",
                 n_sent, n_checked, n_errors);
        $display("full %0d, duplicate %0d, empty %0d, preemptions %0d",
                 n_full, n_dup, n_empty, n_preempt);
        if (n_errors == 0 && pending_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
